// File: hdl/assert_macros.svh
// Assertion macros used by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// File: hdl/atsw_pkg.sv
// Shared types and constants of the terminal screen writer.
`timescale 1ns / 1ps
package atsw_pkg;
   typedef struct packed {
      logic [7:0] attrs;
      logic [7:0] bg;
      logic [7:0] fg;
      logic [7:0] ch;
   } cell_type;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_CELL = 2'd1;
   localparam logic [1:0] KIND_CSI  = 2'd2;

   localparam logic [2:0] CSR_ROWS  = 3'd0;
   localparam logic [2:0] CSR_COLS  = 3'd1;
   localparam logic [2:0] CSR_FG    = 3'd2;
   localparam logic [2:0] CSR_BG    = 3'd3;
   localparam logic [2:0] CSR_ATTRS = 3'd4;

   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_LBR   = 8'h5B;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam cell_type RESET_CELL = '{attrs: 8'd0, bg: 8'd0, fg: 8'd7, ch: CH_SPACE};
endpackage

// File: hdl/ansi_terminal_screen_writer.sv
// Top level of the terminal screen writer: parser, cursor and screen sequencer.
`timescale 1ns / 1ps
// The block takes terminal output bytes one item at a time and keeps a
// character cell screen in a synchronous RAM of 2**clog2(MAX_ROWS) by
// 2**clog2(MAX_COLS) cells, together with a cursor and a small escape parser.
// After reset a clearing pass writes every cell of the screen RAM, one cell
// per cycle, and no item is accepted until it ends; configuration writes are
// taken at any time. An ordinary byte passes through accept, execute and
// deliver steps, and a CSI digit adds a step between execute and deliver,
// because the parameter RAM is read and then written back. A cell read
// passes through accept, execute (which reads the screen RAM) and deliver.
// A line feed or a wrap at the bottom row scrolls: the copy engine moves one
// cell per cycle over (rows-1)*cols cells, then a drain step writes the last
// cell and a fill pass clears the new bottom row, all through the single
// screen RAM write port. The end of a CSI sequence delivers one item per
// parameter (one item if there are none), each parameter being read from
// its RAM before it is sent. Results sit in an output register, so a new item
// can be accepted while the last result still waits on rsp_stall.
module ansi_terminal_screen_writer #(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_COLS   = 128,
   parameter int MAX_PARAMS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_byte_req,
   input  logic [5:0]  req_read_row,
   input  logic [6:0]  req_read_col,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_cell_char,
   output logic [7:0]  rsp_cell_fg,
   output logic [7:0]  rsp_cell_bg,
   output logic [7:0]  rsp_cell_attrs,
   output logic [5:0]  rsp_cursor_row_out,
   output logic [6:0]  rsp_cursor_col_out,
   output logic [7:0]  rsp_csi_final,
   output logic [15:0] rsp_csi_value,
   output logic [3:0]  rsp_csi_index,
   output logic [4:0]  rsp_csi_count,
   output logic        rsp_last
);
   import atsw_pkg::*;

   `include "assert_macros.svh"

   localparam int RW  = $clog2(MAX_ROWS);
   localparam int CW  = $clog2(MAX_COLS);
   localparam int AW  = RW + CW;
   localparam int ERW = $clog2(MAX_ROWS + 1);
   localparam int ECW = $clog2(MAX_COLS + 1);
   localparam int PIW = $clog2(MAX_PARAMS);
   localparam int PSW = $clog2(MAX_PARAMS + 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_EXEC, S_CELLOUT, S_DONE, S_DIGIT,
      S_SCROLL, S_DRAIN, S_FILL, S_PREAD, S_PEMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_NORMAL, PH_ESC, PH_CSI, PH_PARAM
   } phase_type;

   // Configuration registers.
   logic [6:0] rows_ff;
   logic [7:0] cols_ff;
   logic [7:0] fg_ff;
   logic [7:0] bg_ff;
   logic [7:0] attrs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= 7'd24;
         cols_ff  <= 8'd80;
         fg_ff    <= 8'd7;
         bg_ff    <= 8'd0;
         attrs_ff <= 8'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROWS:  rows_ff  <= csr_wdata[6:0];
            CSR_COLS:  cols_ff  <= csr_wdata;
            CSR_FG:    fg_ff    <= csr_wdata;
            CSR_BG:    bg_ff    <= csr_wdata;
            CSR_ATTRS: attrs_ff <= csr_wdata;
            default:   ;
         endcase
      end
   end

   // Sizes in use, clamped to the store.
   logic [ERW-1:0] eff_rows;
   logic [ECW-1:0] eff_cols;

   always_comb begin
      if (rows_ff == 7'd0) begin
         eff_rows = ERW'(1);
      end else if (32'(rows_ff) > 32'(MAX_ROWS)) begin
         eff_rows = ERW'(MAX_ROWS);
      end else begin
         eff_rows = ERW'(rows_ff);
      end
      if (cols_ff == 8'd0) begin
         eff_cols = ECW'(1);
      end else if (32'(cols_ff) > 32'(MAX_COLS)) begin
         eff_cols = ECW'(MAX_COLS);
      end else begin
         eff_cols = ECW'(cols_ff);
      end
   end

   // Registers of the sequencer.
   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [RW-1:0]     cur_row_ff, cur_row_in;
   logic [CW-1:0]     cur_col_ff, cur_col_in;
   logic [PSW-1:0]    slot_ff, slot_in;
   logic [MAX_PARAMS-1:0] pval_ff, pval_in;
   logic [PIW-1:0]    pidx_ff, pidx_in;
   logic [PSW-1:0]    k_ff, k_in;
   logic [PSW-1:0]    cnt_ff, cnt_in;
   logic [RW-1:0]     sr_ff, sr_in;
   logic [CW-1:0]     sc_ff, sc_in;
   logic              wpend_ff, wpend_in;
   logic [AW-1:0]     wa_ff, wa_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              mode_ff, mode_in;
   logic [7:0]        byte_ff, byte_in;
   logic [5:0]        rrow_ff, rrow_in;
   logic [6:0]        rcol_ff, rcol_in;

   logic              out_valid_ff, out_valid_in;
   logic [1:0]        o_kind_ff, o_kind_in;
   cell_type          o_cell_ff, o_cell_in;
   logic [5:0]        o_row_ff, o_row_in;
   logic [6:0]        o_col_ff, o_col_in;
   logic [7:0]        o_final_ff, o_final_in;
   logic [15:0]       o_value_ff, o_value_in;
   logic [3:0]        o_index_ff, o_index_in;
   logic [4:0]        o_count_ff, o_count_in;
   logic              o_last_ff, o_last_in;

   // Memory ports.
   logic              sw_we, s_re;
   logic [AW-1:0]     sw_addr, s_raddr;
   cell_type          sw_data;
   logic [31:0]       s_rdata;
   logic              pw_we, p_re;
   logic [PIW-1:0]    pw_addr, p_raddr;
   logic [15:0]       pw_data, p_rdata;

   atsw_ram #(.WIDTH(32), .DEPTH(2 ** AW)) u_screen (
      .clock (clock),
      .we    (sw_we),
      .waddr (sw_addr),
      .wdata (sw_data),
      .re    (s_re),
      .raddr (s_raddr),
      .rdata (s_rdata)
   );

   atsw_ram #(.WIDTH(16), .DEPTH(2 ** PIW)) u_params (
      .clock (clock),
      .we    (pw_we),
      .waddr (pw_addr),
      .wdata (pw_data),
      .re    (p_re),
      .raddr (p_raddr),
      .rdata (p_rdata)
   );

   // Helper values.
   logic          slot_free;
   logic [RW:0]   row_inc;
   logic [CW:0]   col_inc;
   logic [RW-1:0] bottom_row;
   logic          in_screen;
   logic          rd_in_range;
   logic          is_digit;
   logic          last_col;
   logic          last_row;
   logic [PIW-1:0] slot_idx;
   logic [15:0]   pcur;
   logic [19:0]   pprod;
   logic [PSW:0]  cnt_raw;
   logic [PSW-1:0] n_items;
   logic          k_last;

   // Emission request of this cycle.
   logic          em;
   logic [1:0]    em_kind;
   cell_type      em_cell;
   logic [15:0]   em_value;
   logic [7:0]    em_final;
   logic          em_csi;
   logic          em_last;

   assign slot_free  = !out_valid_ff || !rsp_stall;
   assign row_inc    = {1'b0, cur_row_ff} + (RW + 1)'(1);
   assign col_inc    = {1'b0, cur_col_ff} + (CW + 1)'(1);
   assign bottom_row = RW'(eff_rows - ERW'(1));
   assign in_screen  = (32'(cur_row_ff) < 32'(eff_rows)) && (32'(cur_col_ff) < 32'(eff_cols));
   assign rd_in_range = (32'(rrow_ff) < 32'(MAX_ROWS)) && (32'(rcol_ff) < 32'(MAX_COLS));
   assign is_digit   = (byte_ff >= CH_ZERO) && (byte_ff <= CH_NINE);
   assign last_col   = (32'(sc_ff) + 32'd1) == 32'(eff_cols);
   assign last_row   = (32'(sr_ff) + 32'd2) == 32'(eff_rows);
   assign slot_idx   = (32'(slot_ff) >= 32'(MAX_PARAMS)) ? PIW'(MAX_PARAMS - 1) : PIW'(slot_ff);
   assign pcur       = pval_ff[pidx_ff] ? p_rdata : 16'd0;
   assign pprod      = 20'(pcur) * 20'd10 + 20'(byte_ff - CH_ZERO);
   assign cnt_raw    = {1'b0, slot_ff} + (PSW + 1)'(phase_ff == PH_PARAM);
   assign n_items    = (cnt_ff == '0) ? PSW'(1) : cnt_ff;
   assign k_last     = (k_ff + PSW'(1)) == n_items;

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      slot_in    = slot_ff;
      pval_in    = pval_ff;
      pidx_in    = pidx_ff;
      k_in       = k_ff;
      cnt_in     = cnt_ff;
      sr_in      = sr_ff;
      sc_in      = sc_ff;
      wpend_in   = 1'b0;
      wa_in      = wa_ff;
      clr_in     = clr_ff;
      mode_in    = mode_ff;
      byte_in    = byte_ff;
      rrow_in    = rrow_ff;
      rcol_in    = rcol_ff;

      sw_we   = 1'b0;
      sw_addr = '0;
      sw_data = RESET_CELL;
      s_re    = 1'b0;
      s_raddr = '0;
      pw_we   = 1'b0;
      pw_addr = pidx_ff;
      pw_data = (pprod > 20'd65535) ? 16'hFFFF : pprod[15:0];
      p_re    = 1'b0;
      p_raddr = '0;

      em       = 1'b0;
      em_kind  = KIND_BYTE;
      em_cell  = '0;
      em_value = '0;
      em_final = '0;
      em_csi   = 1'b0;
      em_last  = 1'b1;

      case (state_ff)
         S_CLEAR: begin
            sw_we   = 1'b1;
            sw_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               byte_in  = req_byte_req;
               rrow_in  = req_read_row;
               rcol_in  = req_read_col;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            if (mode_ff) begin
               s_re     = 1'b1;
               s_raddr  = {RW'(rrow_ff), CW'(rcol_ff)};
               state_in = S_CELLOUT;
            end else if (!byte_ff[7]) begin
               case (phase_ff)
                  PH_NORMAL: begin
                     if (byte_ff == CH_ESC) begin
                        phase_in = PH_ESC;
                     end else if (byte_ff == CH_CR) begin
                        cur_col_in = '0;
                     end else if (byte_ff == CH_BS) begin
                        if (cur_col_ff != '0) begin
                           cur_col_in = cur_col_ff - CW'(1);
                        end
                     end else if (byte_ff == CH_LF ||
                                  (byte_ff >= CH_SPACE && byte_ff < CH_DEL && in_screen)) begin
                        // A printable byte writes its cell; a wrap and a line
                        // feed share the new line path below.
                        if (byte_ff != CH_LF) begin
                           sw_we   = 1'b1;
                           sw_addr = {cur_row_ff, cur_col_ff};
                           sw_data = '{attrs: attrs_ff, bg: bg_ff, fg: fg_ff, ch: byte_ff};
                           cur_col_in = col_inc[CW-1:0];
                        end
                        if (byte_ff == CH_LF || 32'(col_inc) >= 32'(eff_cols)) begin
                           cur_col_in = '0;
                           if (32'(row_inc) >= 32'(eff_rows)) begin
                              cur_row_in = bottom_row;
                              sr_in      = '0;
                              sc_in      = '0;
                              state_in   = (eff_rows > ERW'(1)) ? S_SCROLL : S_FILL;
                           end else begin
                              cur_row_in = row_inc[RW-1:0];
                           end
                        end
                     end
                  end
                  PH_ESC: begin
                     if (byte_ff == CH_LBR) begin
                        phase_in = PH_CSI;
                        slot_in  = '0;
                        pval_in  = '0;
                     end else begin
                        phase_in = PH_NORMAL;
                     end
                  end
                  default: begin
                     if (is_digit) begin
                        p_re     = 1'b1;
                        p_raddr  = slot_idx;
                        pidx_in  = slot_idx;
                        phase_in = PH_PARAM;
                        state_in = S_DIGIT;
                     end else if (byte_ff == CH_SEMI) begin
                        phase_in = PH_PARAM;
                        if (32'(slot_ff) + 32'd1 >= 32'(MAX_PARAMS)) begin
                           slot_in = PSW'(MAX_PARAMS - 1);
                        end else begin
                           slot_in = slot_ff + PSW'(1);
                        end
                     end else begin
                        if (32'(cnt_raw) > 32'(MAX_PARAMS)) begin
                           cnt_in = PSW'(MAX_PARAMS);
                        end else begin
                           cnt_in = PSW'(cnt_raw);
                        end
                        slot_in  = cnt_in;
                        phase_in = PH_NORMAL;
                        k_in     = '0;
                        state_in = S_PREAD;
                     end
                  end
               endcase
            end
         end
         S_DIGIT: begin
            pw_we            = 1'b1;
            pval_in[pidx_ff] = 1'b1;
            state_in         = S_DONE;
         end
         S_SCROLL: begin
            // Read the cell one row down, write it in the next cycle.
            s_re     = 1'b1;
            s_raddr  = {sr_ff + RW'(1), sc_ff};
            wpend_in = 1'b1;
            wa_in    = {sr_ff, sc_ff};
            if (wpend_ff) begin
               sw_we   = 1'b1;
               sw_addr = wa_ff;
               sw_data = s_rdata;
            end
            if (last_col) begin
               sc_in = '0;
               sr_in = sr_ff + RW'(1);
               if (last_row) begin
                  state_in = S_DRAIN;
               end
            end else begin
               sc_in = sc_ff + CW'(1);
            end
         end
         S_DRAIN: begin
            sw_we    = 1'b1;
            sw_addr  = wa_ff;
            sw_data  = s_rdata;
            sc_in    = '0;
            state_in = S_FILL;
         end
         S_FILL: begin
            sw_we   = 1'b1;
            sw_addr = {cur_row_ff, sc_ff};
            sw_data = '{attrs: 8'd0, bg: bg_ff, fg: fg_ff, ch: CH_SPACE};
            sc_in   = sc_ff + CW'(1);
            if (last_col) begin
               state_in = S_DONE;
            end
         end
         S_CELLOUT: begin
            if (slot_free) begin
               em       = 1'b1;
               em_kind  = KIND_CELL;
               em_cell  = rd_in_range ? cell_type'(s_rdata) : '0;
               state_in = S_IDLE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               em       = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_PREAD: begin
            p_re     = 1'b1;
            p_raddr  = k_ff[PIW-1:0];
            state_in = S_PEMIT;
         end
         S_PEMIT: begin
            if (slot_free) begin
               em       = 1'b1;
               em_kind  = KIND_CSI;
               em_csi   = 1'b1;
               em_final = byte_ff;
               em_last  = k_last;
               if (cnt_ff != '0 && pval_ff[k_ff[PIW-1:0]]) begin
                  em_value = p_rdata;
               end
               if (k_last) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + PSW'(1);
                  state_in = S_PREAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      out_valid_in = out_valid_ff && rsp_stall;
      o_kind_in  = o_kind_ff;
      o_cell_in  = o_cell_ff;
      o_row_in   = o_row_ff;
      o_col_in   = o_col_ff;
      o_final_in = o_final_ff;
      o_value_in = o_value_ff;
      o_index_in = o_index_ff;
      o_count_in = o_count_ff;
      o_last_in  = o_last_ff;
      if (em) begin
         out_valid_in = 1'b1;
         o_kind_in  = em_kind;
         o_cell_in  = em_cell;
         o_row_in   = 6'(cur_row_in);
         o_col_in   = 7'(cur_col_in);
         o_final_in = em_final;
         o_value_in = em_value;
         o_index_in = em_csi ? 4'(k_ff) : 4'd0;
         o_count_in = em_csi ? 5'(cnt_ff) : 5'd0;
         o_last_in  = em_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         phase_ff     <= PH_NORMAL;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         slot_ff      <= '0;
         pval_ff      <= '0;
         k_ff         <= '0;
         cnt_ff       <= '0;
         sr_ff        <= '0;
         sc_ff        <= '0;
         wpend_ff     <= 1'b0;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         slot_ff      <= slot_in;
         pval_ff      <= pval_in;
         k_ff         <= k_in;
         cnt_ff       <= cnt_in;
         sr_ff        <= sr_in;
         sc_ff        <= sc_in;
         wpend_ff     <= wpend_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
      pidx_ff    <= pidx_in;
      wa_ff      <= wa_in;
      mode_ff    <= mode_in;
      byte_ff    <= byte_in;
      rrow_ff    <= rrow_in;
      rcol_ff    <= rcol_in;
      o_kind_ff  <= o_kind_in;
      o_cell_ff  <= o_cell_in;
      o_row_ff   <= o_row_in;
      o_col_ff   <= o_col_in;
      o_final_ff <= o_final_in;
      o_value_ff <= o_value_in;
      o_index_ff <= o_index_in;
      o_count_ff <= o_count_in;
      o_last_ff  <= o_last_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = o_kind_ff;
   assign rsp_cell_char      = o_cell_ff.ch;
   assign rsp_cell_fg        = o_cell_ff.fg;
   assign rsp_cell_bg        = o_cell_ff.bg;
   assign rsp_cell_attrs     = o_cell_ff.attrs;
   assign rsp_cursor_row_out = o_row_ff;
   assign rsp_cursor_col_out = o_col_ff;
   assign rsp_csi_final      = o_final_ff;
   assign rsp_csi_value      = o_value_ff;
   assign rsp_csi_index      = o_index_ff;
   assign rsp_csi_count      = o_count_ff;
   assign rsp_last           = o_last_ff;

   // An accepted item always starts in the execute step.
   `ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && !req_stall, state_ff == S_EXEC, "accepted item did not reach execute")
   // The scroll copy never writes below the bottom row in use.
   `ASSERT_ALWAYS(a_scroll_rows, clock, reset, !(sw_we && state_ff == S_SCROLL) || (32'(wa_ff) >> CW) < 32'(eff_rows), "scroll write beyond rows in use")
   // A delivered result has a defined kind.
   `ASSERT_ALWAYS(a_kind_code, clock, reset, !rsp_valid || rsp_kind != 2'd3, "result kind out of range")
endmodule

// File: hdl/atsw_ram.sv
// Generic simple dual port RAM with registered read.
`timescale 1ns / 1ps
module atsw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
